FILE: hw/rtl/gamepad_event_to_button_map_top_assert.svh
// assertion macros for the gamepad button map rtl, used by gpmap_event
// expects signals clk and rst_n in the scope of each use
`ifndef GAMEPAD_EVENT_TO_BUTTON_MAP_TOP_ASSERT_SVH
`define GAMEPAD_EVENT_TO_BUTTON_MAP_TOP_ASSERT_SVH

// checked only out of reset
`define GPMAP_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every edge, reset included
`define GPMAP_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/gpmap_pkg.sv
// types, codes and helpers for the gamepad button map block
// no dependencies
`default_nettype none

package gpmap_pkg;

    localparam int MAP_W    = 16;
    localparam int VALUE_W  = 32;
    localparam int CMD_W    = 3;
    localparam int IDX_W    = 4;
    localparam int STATUS_W = 3;
    localparam int DATA_W   = 64;
    localparam int ADDR_W   = 6;
    localparam int REGSEL_W = 3;

    localparam logic [MAP_W-1:0] THRESHOLD_RESET = 16'd16000;

    typedef enum logic [CMD_W-1:0] {
        CMD_SYNC    = 3'd0,
        CMD_HAXIS   = 3'd1,
        CMD_VAXIS   = 3'd2,
        CMD_BUTTON  = 3'd3,
        CMD_NEUTRAL = 3'd4
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 3'd0,
        ST_SENT        = 3'd1,
        ST_BAD_SYNC    = 3'd2,
        ST_BAD_AXIS    = 3'd3,
        ST_BAD_KEY     = 3'd4,
        ST_UNSUPPORTED = 3'd5
    } status_t;

    typedef enum logic [REGSEL_W-1:0] {
        REG_DIRECTION = 3'd0,
        REG_ACTION    = 3'd1,
        REG_EXTRA     = 3'd2,
        REG_SELECT    = 3'd3,
        REG_THRESHOLD = 3'd4
    } reg_sel_t;

    typedef enum logic [IDX_W-1:0] {
        BTN_UP     = 4'd0,
        BTN_DOWN   = 4'd1,
        BTN_LEFT   = 4'd2,
        BTN_RIGHT  = 4'd3,
        BTN_A      = 4'd4,
        BTN_B      = 4'd5,
        BTN_C      = 4'd6,
        BTN_X      = 4'd7,
        BTN_Y      = 4'd8,
        BTN_L      = 4'd9,
        BTN_R      = 4'd10,
        BTN_SELECT = 4'd11,
        BTN_START  = 4'd12
    } button_t;

    typedef struct packed {
        logic [DATA_W-1:0] direction_masks;
        logic [DATA_W-1:0] action_masks;
        logic [DATA_W-1:0] extra_masks;
        logic [MAP_W-1:0]  select_mask;
        logic [MAP_W-1:0]  axis_threshold;
    } cfg_t;

    // mask that a button index stands for, zero for unknown indexes
    function automatic logic [MAP_W-1:0] mask_of(cfg_t c, logic [IDX_W-1:0] idx);
        logic [MAP_W-1:0] m;
        m = '0;
        case (button_t'(idx))
            BTN_UP:     m = c.direction_masks[15:0];
            BTN_DOWN:   m = c.direction_masks[31:16];
            BTN_LEFT:   m = c.direction_masks[47:32];
            BTN_RIGHT:  m = c.direction_masks[63:48];
            BTN_A:      m = c.action_masks[15:0];
            BTN_B:      m = c.action_masks[31:16];
            BTN_C:      m = c.action_masks[47:32];
            BTN_START:  m = c.action_masks[63:48];
            BTN_X:      m = c.extra_masks[15:0];
            BTN_Y:      m = c.extra_masks[31:16];
            BTN_L:      m = c.extra_masks[47:32];
            BTN_R:      m = c.extra_masks[63:48];
            BTN_SELECT: m = c.select_mask;
            default:    m = '0;
        endcase
        return m;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/gpmap_cfg.sv
// apb register file for the gamepad button map masks and threshold
// depends on gpmap_pkg
`default_nettype none

module gpmap_cfg (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         psel,
    input  wire logic                         penable,
    input  wire logic                         pwrite,
    input  wire logic [gpmap_pkg::ADDR_W-1:0] paddr,
    input  wire logic [gpmap_pkg::DATA_W-1:0] pwdata,
    output logic      [gpmap_pkg::DATA_W-1:0] prdata,
    output logic                              pready,
    output gpmap_pkg::cfg_t                   cfg
);
    import gpmap_pkg::*;

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_sel_t sel;
    logic     wr_en;

    // registers sit on 8-byte boundaries
    assign sel    = reg_sel_t'(paddr[ADDR_W-1:ADDR_W-REGSEL_W]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (sel)
                REG_DIRECTION: cfg_next.direction_masks = pwdata;
                REG_ACTION:    cfg_next.action_masks    = pwdata;
                REG_EXTRA:     cfg_next.extra_masks     = pwdata;
                REG_SELECT:    cfg_next.select_mask     = pwdata[MAP_W-1:0];
                REG_THRESHOLD: cfg_next.axis_threshold  = pwdata[MAP_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (sel)
            REG_DIRECTION: prdata = cfg_reg.direction_masks;
            REG_ACTION:    prdata = cfg_reg.action_masks;
            REG_EXTRA:     prdata = cfg_reg.extra_masks;
            REG_SELECT:    prdata = {{(DATA_W-MAP_W){1'b0}}, cfg_reg.select_mask};
            REG_THRESHOLD: prdata = {{(DATA_W-MAP_W){1'b0}}, cfg_reg.axis_threshold};
            default:       prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.direction_masks <= '0;
            cfg_reg.action_masks    <= '0;
            cfg_reg.extra_masks     <= '0;
            cfg_reg.select_mask     <= '0;
            cfg_reg.axis_threshold  <= THRESHOLD_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gpmap_map_build.sv
// builds the button map from held buttons and both axes
// depends on gpmap_pkg
`default_nettype none

module gpmap_map_build (
    input  gpmap_pkg::cfg_t                  cfg,
    input  wire logic [gpmap_pkg::MAP_W-1:0] held,
    input  wire logic [gpmap_pkg::MAP_W-1:0] haxis,
    input  wire logic [gpmap_pkg::MAP_W-1:0] vaxis,
    output logic      [gpmap_pkg::MAP_W-1:0] map
);
    import gpmap_pkg::*;

    localparam int CMP_W = MAP_W + 2;

    logic [MAP_W-1:0]        up_m;
    logic [MAP_W-1:0]        down_m;
    logic [MAP_W-1:0]        left_m;
    logic [MAP_W-1:0]        right_m;
    logic signed [CMP_W-1:0] thr_pos;
    logic signed [CMP_W-1:0] thr_neg;
    logic signed [CMP_W-1:0] h_s;
    logic signed [CMP_W-1:0] v_s;
    logic [MAP_W-1:0]        raw;
    logic [MAP_W-1:0]        lr_clr;

    assign up_m    = cfg.direction_masks[15:0];
    assign down_m  = cfg.direction_masks[31:16];
    assign left_m  = cfg.direction_masks[47:32];
    assign right_m = cfg.direction_masks[63:48];

    // threshold is unsigned, axes are signed 16-bit
    assign thr_pos = signed'({2'b00, cfg.axis_threshold});
    assign thr_neg = -thr_pos;
    assign h_s     = signed'({{2{haxis[MAP_W-1]}}, haxis});
    assign v_s     = signed'({{2{vaxis[MAP_W-1]}}, vaxis});

    always_comb
    begin
        raw = held;
        if (h_s <= thr_neg) raw = raw | left_m;
        if (h_s >= thr_pos) raw = raw | right_m;
        if (v_s <= thr_neg) raw = raw | up_m;
        if (v_s >= thr_pos) raw = raw | down_m;
        // opposing pairs cancel, left/right first
        lr_clr = raw;
        if ((|(raw & left_m)) && (|(raw & right_m)))
            lr_clr = raw & ~(left_m | right_m);
        map = lr_clr;
        if ((|(lr_clr & up_m)) && (|(lr_clr & down_m)))
            map = lr_clr & ~(up_m | down_m);
    end

endmodule

`default_nettype wire

FILE: hw/rtl/gpmap_event.sv
// event stage: input register, decode, state update and result register
// depends on gpmap_pkg, gpmap_map_build and the assertion header
`default_nettype none

`include "gamepad_event_to_button_map_top_assert.svh"

module gpmap_event (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  gpmap_pkg::cfg_t                     cfg,
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [gpmap_pkg::CMD_W-1:0]    command,
    input  wire logic [gpmap_pkg::IDX_W-1:0]    button_index,
    input  wire logic [gpmap_pkg::VALUE_W-1:0]  value,
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [gpmap_pkg::STATUS_W-1:0] status,
    output logic      [gpmap_pkg::MAP_W-1:0]    button_map
);
    import gpmap_pkg::*;

    // input register
    logic               s1_valid_reg;
    logic               s1_valid_next;
    logic [CMD_W-1:0]   s1_cmd_reg;
    logic [IDX_W-1:0]   s1_idx_reg;
    logic [VALUE_W-1:0] s1_value_reg;

    // block state
    logic [MAP_W-1:0] held_reg;
    logic [MAP_W-1:0] held_next;
    logic [MAP_W-1:0] committed_reg;
    logic [MAP_W-1:0] committed_next;
    logic [MAP_W-1:0] haxis_reg;
    logic [MAP_W-1:0] haxis_next;
    logic [MAP_W-1:0] vaxis_reg;
    logic [MAP_W-1:0] vaxis_next;

    // result register
    logic            out_valid_reg;
    logic            out_valid_next;
    status_t         out_status_reg;
    logic [MAP_W-1:0] out_map_reg;

    logic             out_free;
    logic             s1_fire;
    logic             in_fire;
    status_t          status_c;
    logic [MAP_W-1:0] map_c;
    logic [MAP_W-1:0] built_map;
    logic [MAP_W-1:0] key_mask;
    logic             value_zero;
    logic             value_key;
    logic             value_axis;

    assign out_free = !out_valid_reg || !out_stall;
    assign s1_fire  = s1_valid_reg && out_free;
    assign in_stall = s1_valid_reg && !out_free;
    assign in_fire  = in_valid && !in_stall;

    assign s1_valid_next  = in_fire || (s1_valid_reg && !s1_fire);
    assign out_valid_next = s1_fire || (out_valid_reg && out_stall);

    assign out_valid  = out_valid_reg;
    assign status     = out_status_reg;
    assign button_map = out_map_reg;

    gpmap_map_build u_map_build (
        .cfg   (cfg),
        .held  (held_reg),
        .haxis (haxis_reg),
        .vaxis (vaxis_reg),
        .map   (built_map)
    );

    assign key_mask   = mask_of(cfg, s1_idx_reg);
    assign value_zero = (s1_value_reg == '0);
    assign value_key  = (s1_value_reg[VALUE_W-1:1] == '0);
    // fits in 16 signed bits when the top bits are all sign
    assign value_axis = (&s1_value_reg[VALUE_W-1:MAP_W-1]) || !(|s1_value_reg[VALUE_W-1:MAP_W-1]);

    always_comb
    begin
        held_next      = held_reg;
        committed_next = committed_reg;
        haxis_next     = haxis_reg;
        vaxis_next     = vaxis_reg;
        status_c       = ST_OK;
        map_c          = '0;
        if (s1_fire)
        begin
            case (cmd_t'(s1_cmd_reg))
                CMD_SYNC:
                begin
                    if (!value_zero)
                        status_c = ST_BAD_SYNC;
                    else if (built_map != committed_reg)
                    begin
                        committed_next = built_map;
                        map_c          = built_map;
                        status_c       = ST_SENT;
                    end
                end
                CMD_HAXIS:
                begin
                    if (!value_axis)
                        status_c = ST_BAD_AXIS;
                    else
                        haxis_next = s1_value_reg[MAP_W-1:0];
                end
                CMD_VAXIS:
                begin
                    if (!value_axis)
                        status_c = ST_BAD_AXIS;
                    else
                        vaxis_next = s1_value_reg[MAP_W-1:0];
                end
                CMD_BUTTON:
                begin
                    if (s1_idx_reg > IDX_W'(BTN_START))
                        status_c = ST_UNSUPPORTED;
                    else if (!value_key)
                        status_c = ST_BAD_KEY;
                    else if (s1_value_reg[0])
                        held_next = held_reg | key_mask;
                    else
                        held_next = held_reg & ~key_mask;
                end
                CMD_NEUTRAL:
                begin
                    held_next      = '0;
                    committed_next = '0;
                    haxis_next     = '0;
                    vaxis_next     = '0;
                    status_c       = ST_SENT;
                end
                default: status_c = ST_UNSUPPORTED;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            held_reg      <= '0;
            committed_reg <= '0;
            haxis_reg     <= '0;
            vaxis_reg     <= '0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            held_reg      <= held_next;
            committed_reg <= committed_next;
            haxis_reg     <= haxis_next;
            vaxis_reg     <= vaxis_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_cmd_reg   <= command;
            s1_idx_reg   <= button_index;
            s1_value_reg <= value;
        end
        if (s1_fire)
        begin
            out_status_reg <= status_c;
            out_map_reg    <= map_c;
        end
    end

    // a shown sent map is always the committed one
    `GPMAP_ASSERT(a_sent_is_committed, (out_valid_reg && out_status_reg == ST_SENT) |-> (out_map_reg == committed_reg), "sent map differs from committed map")
    // only a sent result carries a map
    `GPMAP_ASSERT(a_map_zero_unsent, (out_valid_reg && out_status_reg != ST_SENT) |-> (out_map_reg == '0), "map nonzero on unsent result")
    // neutralize clears all state
    `GPMAP_ASSERT(a_neutral_clears, (s1_fire && s1_cmd_reg == CMD_NEUTRAL) |=> (held_reg == '0 && committed_reg == '0 && haxis_reg == '0 && vaxis_reg == '0), "neutralize left state behind")
    // back-pressure only when the input register holds an item
    `GPMAP_ASSERT_ALWAYS(a_stall_needs_item, in_stall |-> s1_valid_reg, "input stalled with empty stage")

endmodule

`default_nettype wire

FILE: hw/rtl/gamepad_event_to_button_map_top.sv
// top level of the gamepad event to button map block
// depends on gpmap_pkg, gpmap_cfg, gpmap_event (and gpmap_map_build below it)
`default_nettype none

// Gamepad event to button map. Each input transfer is one gamepad event
// (command, button_index, value): synchronize, horizontal axis, vertical
// axis, button press/release, or neutralize. Every event gives exactly one
// output transfer (status, button_map). Button events update a 16-bit held
// map through the mask of that button; axis events store a 16-bit signed
// position. A synchronize builds the map from the held buttons plus
// directions from axes whose magnitude reaches axis_threshold, cancels an
// opposing pair (left/right, up/down) when both are set, and sends it
// (status 1) only when it differs from the last sent map; otherwise status
// 0. Neutralize clears all state and always sends a zero map. Bad values and
// unknown commands or buttons give error statuses and change nothing.
// Timing: one event per clock sustained while the result side does not stall;
// each event passes through the input register, then the result register.
// Both channels use valid/stall; the input side keeps taking events while
// a result waits, and stalls only when the result register is full and
// stalled with another event already registered. The state feedback loop
// reads held map, axes and committed map and rewrites them through the map
// builder within the same cycle.
// Configuration: APB, 64-bit data, registers at byte offsets 0x00 direction
// masks (up, down, left, right lanes, low first), 0x08 action masks (a, b, c,
// start), 0x10 extra masks (x, y, l, r), 0x18 select mask, 0x20 axis
// threshold (reset 16000). pready is tied high; write only while idle.

module gamepad_event_to_button_map_top (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    // configuration port
    input  wire logic                           psel,
    input  wire logic                           penable,
    input  wire logic                           pwrite,
    input  wire logic [gpmap_pkg::ADDR_W-1:0]   paddr,
    input  wire logic [gpmap_pkg::DATA_W-1:0]   pwdata,
    output logic      [gpmap_pkg::DATA_W-1:0]   prdata,
    output logic                                pready,
    // event channel
    input  wire logic                           in_valid,
    output logic                                in_stall,
    input  wire logic [gpmap_pkg::CMD_W-1:0]    command,
    input  wire logic [gpmap_pkg::IDX_W-1:0]    button_index,
    input  wire logic [gpmap_pkg::VALUE_W-1:0]  value,
    // result channel
    output logic                                out_valid,
    input  wire logic                           out_stall,
    output logic      [gpmap_pkg::STATUS_W-1:0] status,
    output logic      [gpmap_pkg::MAP_W-1:0]    button_map
);
    import gpmap_pkg::*;

    // masks and threshold as currently programmed
    cfg_t cfg;

    gpmap_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // input register, decode, state and result register
    gpmap_event u_event (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .button_index (button_index),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .button_map   (button_map)
    );

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 1ps
// self-checking testbench for gamepad_event_to_button_map_top: directed events, then random
// event streams checked against a behavioral button map predictor; needs gpmap_pkg and the rtl

module tb;
    import gpmap_pkg::*;

    // codes the package leaves unnamed: reserved commands and button indexes
    localparam logic [CMD_W-1:0] CMD_RSVD_LO = 3'd5;
    localparam logic [CMD_W-1:0] CMD_RSVD_HI = 3'd7;
    localparam logic [IDX_W-1:0] BTN_RSVD_LO = 4'd13;
    localparam logic [IDX_W-1:0] BTN_RSVD_HI = 4'd15;

    // key states and the legal axis range
    localparam int KEY_RELEASE = 0;
    localparam int KEY_PRESS   = 1;
    localparam int AXIS_MIN    = -32768;
    localparam int AXIS_MAX    = 32767;

    // run shape
    localparam int PHASES           = 6;
    localparam int PRESSURE_PHASE   = 4;
    localparam int ITEMS_PER_PHASE  = 180;
    localparam int PRESSURE_ITEMS   = 40;
    localparam int LONG_HOLD_CYCLES = 200;
    localparam int DRAIN_CYCLES     = 6;
    localparam int TIMEOUT_NS       = 2_000_000;

    typedef enum {MASK_ZERO, MASK_ALL, MASK_ONEHOT, MASK_RANDOM} mask_style_t;

    // one event; has_fixed marks a row whose expected result is typed in
    typedef struct {
        logic [CMD_W-1:0]          cmd;
        logic [IDX_W-1:0]          idx;
        logic signed [VALUE_W-1:0] val;
        bit                        has_fixed;
        status_t                   st;
        logic [MAP_W-1:0]          bmap;
    } gamepad_event_t;

    typedef struct packed {
        status_t          st;
        logic [MAP_W-1:0] bmap;
    } map_result_t;

    // dut ports; the inputs are all known from time zero
    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [ADDR_W-1:0]   paddr        = '0;
    logic [DATA_W-1:0]   pwdata       = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;
    logic                in_valid     = 1'b0;
    logic                in_stall;
    logic [CMD_W-1:0]    command      = '0;
    logic [IDX_W-1:0]    button_index = '0;
    logic [VALUE_W-1:0]  value        = '0;
    logic                out_valid;
    logic                out_stall    = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [MAP_W-1:0]    button_map;

    // predictor copy of the configuration
    logic [DATA_W-1:0] direction_cfg = '0;
    logic [DATA_W-1:0] action_cfg    = '0;
    logic [DATA_W-1:0] extra_cfg     = '0;
    logic [MAP_W-1:0]  select_cfg    = '0;
    logic [MAP_W-1:0]  threshold_cfg = THRESHOLD_RESET;

    // predictor copy of the block state
    logic [MAP_W-1:0]        held_map      = '0;
    logic [MAP_W-1:0]        committed_map = '0;
    logic signed [MAP_W-1:0] horiz_pos     = '0;
    logic signed [MAP_W-1:0] vert_pos      = '0;

    map_result_t    expected_results[$];
    gamepad_event_t directed_rows[$];
    map_result_t    oldest_expected;
    int             failures = 0;

    // idling knobs, percent of cycles
    int send_idle_pct = 0;
    int stall_pct     = 0;

    // long receiver hold-off: requested by the stimulus, counted by the stall process
    int hold_requests = 0;
    int hold_served   = 0;
    int hold_left     = 0;

    gamepad_event_to_button_map_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .button_index (button_index),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .button_map   (button_map)
    );

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // applies one event to the predictor state and returns the result it causes
    function automatic map_result_t predict_button_map(logic [CMD_W-1:0] cmd,
                                                       logic [IDX_W-1:0] idx,
                                                       logic signed [VALUE_W-1:0] val);
        map_result_t      r;
        logic [MAP_W-1:0] m;
        logic [MAP_W-1:0] up_m;
        logic [MAP_W-1:0] down_m;
        logic [MAP_W-1:0] left_m;
        logic [MAP_W-1:0] right_m;
        int               thr;
        int               h;
        int               v;
        r.st   = ST_OK;
        r.bmap = '0;
        up_m    = direction_cfg[15:0];
        down_m  = direction_cfg[31:16];
        left_m  = direction_cfg[47:32];
        right_m = direction_cfg[63:48];
        thr = int'(threshold_cfg);
        h   = horiz_pos;
        v   = vert_pos;
        case (cmd)
            CMD_SYNC:
            begin
                if (val != 0)
                begin
                    r.st = ST_BAD_SYNC;
                end
                else
                begin
                    m = held_map;
                    if (h <= -thr) m |= left_m;
                    if (h >= thr)  m |= right_m;
                    if (v <= -thr) m |= up_m;
                    if (v >= thr)  m |= down_m;
                    // opposing directions cancel each other
                    if ((m & left_m) != 0 && (m & right_m) != 0) m &= ~(left_m | right_m);
                    if ((m & up_m) != 0 && (m & down_m) != 0)    m &= ~(up_m | down_m);
                    if (m != committed_map)
                    begin
                        committed_map = m;
                        r.st   = ST_SENT;
                        r.bmap = m;
                    end
                end
            end
            CMD_HAXIS, CMD_VAXIS:
            begin
                if (val < AXIS_MIN || val > AXIS_MAX)
                    r.st = ST_BAD_AXIS;
                else if (cmd == CMD_HAXIS)
                    horiz_pos = val[15:0];
                else
                    vert_pos = val[15:0];
            end
            CMD_BUTTON:
            begin
                if (idx > BTN_START)
                begin
                    r.st = ST_UNSUPPORTED;
                end
                else if (val != KEY_RELEASE && val != KEY_PRESS)
                begin
                    r.st = ST_BAD_KEY;
                end
                else
                begin
                    case (idx)
                        BTN_UP:     m = direction_cfg[15:0];
                        BTN_DOWN:   m = direction_cfg[31:16];
                        BTN_LEFT:   m = direction_cfg[47:32];
                        BTN_RIGHT:  m = direction_cfg[63:48];
                        BTN_A:      m = action_cfg[15:0];
                        BTN_B:      m = action_cfg[31:16];
                        BTN_C:      m = action_cfg[47:32];
                        BTN_START:  m = action_cfg[63:48];
                        BTN_X:      m = extra_cfg[15:0];
                        BTN_Y:      m = extra_cfg[31:16];
                        BTN_L:      m = extra_cfg[47:32];
                        BTN_R:      m = extra_cfg[63:48];
                        BTN_SELECT: m = select_cfg;
                        default:    m = '0;
                    endcase
                    if (val == KEY_PRESS)
                        held_map |= m;
                    else
                        held_map &= ~m;
                end
            end
            CMD_NEUTRAL:
            begin
                held_map      = '0;
                committed_map = '0;
                horiz_pos     = '0;
                vert_pos      = '0;
                r.st          = ST_SENT;
            end
            default:
                r.st = ST_UNSUPPORTED;
        endcase
        return r;
    endfunction

    // one 16-bit mask lane in the given style
    function automatic logic [MAP_W-1:0] lane_value(mask_style_t style);
        case (style)
            MASK_ZERO:   return '0;
            MASK_ALL:    return '1;
            MASK_ONEHOT: return 16'h0001 << $urandom_range(MAP_W - 1);
            default:     return MAP_W'($urandom);
        endcase
    endfunction

    // random event, mostly well formed, aimed at the axis threshold edges
    function automatic gamepad_event_t random_event();
        gamepad_event_t ev;
        int             pick;
        int             thr;
        int             v;
        pick = $urandom_range(99);
        thr  = int'(threshold_cfg);
        ev.idx       = IDX_W'($urandom);
        ev.val       = $urandom;
        ev.has_fixed = 1'b0;
        ev.st        = ST_OK;
        ev.bmap      = '0;
        if (pick < 35)
        begin
            ev.cmd = CMD_BUTTON;
            if ($urandom_range(9) == 0)
                ev.idx = IDX_W'($urandom_range(BTN_RSVD_HI, BTN_RSVD_LO));
            else
                ev.idx = IDX_W'($urandom_range(BTN_START));
            // a few keep the random word as a bad key state
            if ($urandom_range(11) != 0)
                ev.val = $urandom_range(KEY_PRESS);
        end
        else if (pick < 60)
        begin
            ev.cmd = $urandom_range(1) ? CMD_HAXIS : CMD_VAXIS;
            v = int'(ev.val);
            case ($urandom_range(6))
                0, 1: v = int'($urandom_range(AXIS_MAX - AXIS_MIN)) + AXIS_MIN;
                2:    v = thr + int'($urandom_range(2)) - 1;
                3:    v = -thr + int'($urandom_range(2)) - 1;
                4:    v = $urandom_range(1) ? AXIS_MAX : AXIS_MIN;
                5:    v = $urandom_range(1) ? AXIS_MAX + 1 : AXIS_MIN - 1;
                default: ;
            endcase
            ev.val = v;
        end
        else if (pick < 95)
        begin
            ev.cmd = CMD_SYNC;
            if ($urandom_range(19) != 0)
                ev.val = '0;
        end
        else if (pick < 98)
        begin
            ev.cmd = CMD_NEUTRAL;
        end
        else
        begin
            ev.cmd = CMD_W'($urandom_range(CMD_RSVD_HI, CMD_RSVD_LO));
        end
        return ev;
    endfunction

    // apb write: setup cycle, then access cycle, register taken when pready is high
    task automatic cfg_write(reg_sel_t sel, logic [DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {sel, 3'b000};
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (sel)
            REG_DIRECTION: direction_cfg = data;
            REG_ACTION:    action_cfg    = data;
            REG_EXTRA:     extra_cfg     = data;
            REG_SELECT:    select_cfg    = data[MAP_W-1:0];
            REG_THRESHOLD: threshold_cfg = data[MAP_W-1:0];
            default: ;
        endcase
    endtask

    task automatic configure(mask_style_t style, logic [MAP_W-1:0] thr);
        cfg_write(REG_DIRECTION, {lane_value(style), lane_value(style),
                                  lane_value(style), lane_value(style)});
        cfg_write(REG_ACTION,    {lane_value(style), lane_value(style),
                                  lane_value(style), lane_value(style)});
        cfg_write(REG_EXTRA,     {lane_value(style), lane_value(style),
                                  lane_value(style), lane_value(style)});
        cfg_write(REG_SELECT,    DATA_W'(lane_value(style)));
        cfg_write(REG_THRESHOLD, DATA_W'(thr));
    endtask

    // offer one event until its transfer, record what it should produce, then idle at random
    task automatic offer_event(gamepad_event_t ev);
        map_result_t predicted;
        in_valid     <= 1'b1;
        command      <= ev.cmd;
        button_index <= ev.idx;
        value        <= ev.val;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        // transfer taken at this edge
        predicted = predict_button_map(ev.cmd, ev.idx, ev.val);
        if (ev.has_fixed)
            expected_results.push_back('{st: ev.st, bmap: ev.bmap});
        else
            expected_results.push_back(predicted);
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < send_idle_pct);
        end
    endtask

    // wait for every outstanding result, then let the pipeline settle
    task automatic drain_results();
        while (expected_results.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // receiver: random stall, or a long hold-off when one is requested
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_stall <= 1'b0;
        end
        else if (hold_served != hold_requests)
        begin
            hold_served = hold_served + 1;
            hold_left   = LONG_HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left = hold_left - 1;
            out_stall <= 1'b1;
        end
        else
        begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result checker: each result transfer against the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("result transfer with nothing expected: status %0d button_map %h",
                       status, button_map);
                failures = failures + 1;
            end
            else
            begin
                oldest_expected = expected_results.pop_front();
                if (status !== oldest_expected.st)
                begin
                    $error("status mismatch: expected %0d actual %0d",
                           oldest_expected.st, status);
                    failures = failures + 1;
                end
                if (button_map !== oldest_expected.bmap)
                begin
                    $error("button_map mismatch: expected %h actual %h",
                           oldest_expected.bmap, button_map);
                    failures = failures + 1;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        // directed events; the typed-in results are error codes, neutralize, the first sync after
        // reset, the two in-range axis values and the first left press; the rest use the predictor
        directed_rows.push_back('{CMD_SYNC, BTN_UP, 32'sd0, 1'b1, ST_OK, 16'h0000});
        directed_rows.push_back('{CMD_SYNC, BTN_UP, 32'sd1, 1'b1, ST_BAD_SYNC, 16'h0000});
        directed_rows.push_back('{CMD_SYNC, BTN_R, 32'sh8000_0000, 1'b1, ST_BAD_SYNC, 16'h0});
        directed_rows.push_back('{CMD_HAXIS, BTN_UP, AXIS_MAX, 1'b1, ST_OK, 16'h0000});
        directed_rows.push_back('{CMD_HAXIS, BTN_UP, AXIS_MAX + 1, 1'b1, ST_BAD_AXIS, 16'h0});
        directed_rows.push_back('{CMD_HAXIS, BTN_UP, 32'sh8000_0000, 1'b1, ST_BAD_AXIS, 16'h0});
        directed_rows.push_back('{CMD_VAXIS, BTN_UP, AXIS_MIN - 1, 1'b1, ST_BAD_AXIS, 16'h0});
        directed_rows.push_back('{CMD_VAXIS, BTN_UP, AXIS_MIN, 1'b1, ST_OK, 16'h0000});
        directed_rows.push_back('{CMD_VAXIS, BTN_UP, 32'sh7fff_ffff, 1'b1, ST_BAD_AXIS, 16'h0});
        directed_rows.push_back('{CMD_SYNC, BTN_UP, 32'sd0, 1'b0, ST_OK, 16'h0000});
        directed_rows.push_back('{CMD_SYNC, BTN_UP, 32'sd0, 1'b0, ST_OK, 16'h0000});
        directed_rows.push_back('{CMD_BUTTON, BTN_LEFT, KEY_PRESS, 1'b1, ST_OK, 16'h0000});
        directed_rows.push_back('{CMD_SYNC, BTN_UP, 32'sd0, 1'b0, ST_OK, 16'h0000});
        directed_rows.push_back('{CMD_BUTTON, BTN_DOWN, KEY_PRESS, 1'b0, ST_OK, 16'h0000});
        directed_rows.push_back('{CMD_SYNC, BTN_UP, 32'sd0, 1'b0, ST_OK, 16'h0000});
        directed_rows.push_back('{CMD_BUTTON, BTN_RSVD_LO, KEY_PRESS, 1'b1, ST_UNSUPPORTED, 16'h0});
        directed_rows.push_back('{CMD_BUTTON, BTN_RSVD_HI, KEY_RELEASE, 1'b1, ST_UNSUPPORTED, 16'h0});
        directed_rows.push_back('{CMD_BUTTON, BTN_A, 32'sd2, 1'b1, ST_BAD_KEY, 16'h0000});
        directed_rows.push_back('{CMD_BUTTON, BTN_START, -32'sd1, 1'b1, ST_BAD_KEY, 16'h0000});
        directed_rows.push_back('{CMD_BUTTON, BTN_SELECT, KEY_PRESS, 1'b0, ST_OK, 16'h0000});
        directed_rows.push_back('{CMD_BUTTON, BTN_LEFT, KEY_RELEASE, 1'b0, ST_OK, 16'h0000});
        directed_rows.push_back('{CMD_SYNC, BTN_UP, 32'sd0, 1'b0, ST_OK, 16'h0000});
        directed_rows.push_back('{CMD_RSVD_LO, BTN_UP, 32'sd0, 1'b1, ST_UNSUPPORTED, 16'h0000});
        directed_rows.push_back('{CMD_RSVD_HI, BTN_R, -32'sd1, 1'b1, ST_UNSUPPORTED, 16'h0000});
        directed_rows.push_back('{CMD_NEUTRAL, BTN_UP, 32'sd0, 1'b1, ST_SENT, 16'h0000});
        directed_rows.push_back('{CMD_SYNC, BTN_UP, 32'sd0, 1'b0, ST_OK, 16'h0000});

        // reset once
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // distinct bit per button so every directed map is easy to read;
        // the threshold keeps its reset value here
        cfg_write(REG_DIRECTION, {16'h0008, 16'h0004, 16'h0002, 16'h0001});
        cfg_write(REG_ACTION,    {16'h1000, 16'h0040, 16'h0020, 16'h0010});
        cfg_write(REG_EXTRA,     {16'h0400, 16'h0200, 16'h0100, 16'h0080});
        cfg_write(REG_SELECT,    DATA_W'(16'h0800));

        foreach (directed_rows[i])
            offer_event(directed_rows[i]);

        // random phases: each with its own idling pattern and register setting
        for (int p = 0; p < PHASES; p++)
        begin
            in_valid <= 1'b0;
            drain_results();
            case (p)
                0:
                begin
                    // no idling at all
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    configure(MASK_ONEHOT, MAP_W'($urandom_range(AXIS_MAX, 1)));
                end
                1:
                begin
                    // sender mostly idle, every mask bit set, zero threshold
                    send_idle_pct = 78;
                    stall_pct     = 0;
                    configure(MASK_ALL, '0);
                end
                2:
                begin
                    // receiver mostly stalled, threshold 0x8000, reached only by the most negative axis value
                    send_idle_pct = 0;
                    stall_pct     = 78;
                    configure(MASK_RANDOM, 16'h8000);
                end
                3:
                begin
                    // light idling on both sides, threshold past every axis value
                    send_idle_pct = 12;
                    stall_pct     = 12;
                    configure(MASK_ONEHOT, '1);
                end
                4:
                begin
                    // back to back events against a long hold-off
                    send_idle_pct = 0;
                    stall_pct     = 0;
                    configure(MASK_ZERO, THRESHOLD_RESET);
                end
                default:
                begin
                    send_idle_pct = 12;
                    stall_pct     = 12;
                    configure(MASK_RANDOM, MAP_W'($urandom_range(AXIS_MAX + 1)));
                end
            endcase
            if (p == PRESSURE_PHASE)
            begin
                // receiver holds off while the sender keeps offering, so the input stalls
                hold_requests = hold_requests + 1;
                repeat (PRESSURE_ITEMS) offer_event(random_event());
            end
            repeat (ITEMS_PER_PHASE) offer_event(random_event());
        end

        in_valid <= 1'b0;
        drain_results();

        if (failures == 0)
            $display("[gamepad_event_to_button_map_top] OK");
        else
            $display("[gamepad_event_to_button_map_top] ERROR");
        $finish;
    end

    // run limit, far beyond the slowest correct run
    initial
    begin
        #(TIMEOUT_NS);
        $display("[gamepad_event_to_button_map_top] ERROR");
        $finish;
    end

endmodule
